FILE: hdl/mocd_pkg.sv
// Shared types, widths, register codes and reset values of the clock divider.
package mocd_pkg;

  localparam int unsigned NUM_OUTPUTS = 6;
  localparam int unsigned OUT_IDX_W   = $clog2(NUM_OUTPUTS);
  localparam int unsigned CNT_W       = 7;   // beat counter
  localparam int unsigned LEN_W       = 8;   // reset_length register
  localparam int unsigned DIV_W       = 9;   // divisor registers
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = DIV_W;
  localparam int unsigned MOD_STEPS   = LEN_W;  // dividend bits, one per cycle
  localparam int unsigned MOD_CNT_W   = $clog2(MOD_STEPS);

  // Largest usable length: span of the beat counter.
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(1 << CNT_W);
  localparam logic [DIV_W-1:0] DIV_MAX = DIV_W'(256);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LENGTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR_OUT1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACKBEAT_MASK = 3'd7;

  localparam logic [LEN_W-1:0]       RESET_LENGTH_RST  = 8'd32;
  localparam logic [NUM_OUTPUTS-1:0] BACKBEAT_MASK_RST = '0;

  function automatic logic [DIV_W-1:0] divisor_rst(input logic [OUT_IDX_W-1:0] idx);
    logic [DIV_W-1:0] val;
    unique case (idx)
      3'd0:    val = 9'd1;
      3'd1:    val = 9'd2;
      3'd2:    val = 9'd4;
      3'd3:    val = 9'd8;
      3'd4:    val = 9'd3;
      3'd5:    val = 9'd5;
      default: val = 9'd1;
    endcase
    return val;
  endfunction

  // Controller to datapath commands.
  typedef struct packed {
    logic                 capture;      // take the input beat
    logic                 div_start;    // launch the shared modulo unit
    logic                 div_wrap;     // operands: count+1 mod length
    logic                 wrap_commit;  // store the wrapped count
    logic                 req_load;     // load length minus one
    logic                 bit_commit;   // store the current output bit
    logic                 emit;         // move the result into the output stage
    logic [OUT_IDX_W-1:0] out_idx;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic edge_seen;
    logic req_seen;
    logic div_busy;
    logic div_done;
    logic pass;       // current output has an effective divisor of one
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/mocd_mod.sv
// Bit-serial restoring modulo unit: one dividend bit per cycle.
module mocd_mod (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [mocd_pkg::LEN_W-1:0]    dividend_i,
  input  logic [mocd_pkg::DIV_W-1:0]    divisor_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [mocd_pkg::LEN_W-1:0]    rem_o
);

  logic                           busy_q;
  logic                           done_q;
  logic [mocd_pkg::MOD_CNT_W-1:0] cnt_q;
  logic [mocd_pkg::LEN_W-1:0]     dvd_q;
  logic [mocd_pkg::DIV_W-1:0]     div_q;
  logic [mocd_pkg::LEN_W-1:0]     rem_q;
  logic [mocd_pkg::DIV_W-1:0]     trial;
  logic [mocd_pkg::DIV_W-1:0]     rem_d;

  // Shift in the next dividend bit, subtract when it fits.
  always_comb begin
    trial = {rem_q, dvd_q[mocd_pkg::LEN_W-1]};
    rem_d = (trial >= div_q) ? trial - div_q : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == mocd_pkg::MOD_CNT_W'(mocd_pkg::MOD_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[mocd_pkg::LEN_W-2:0], 1'b0};
      rem_q <= rem_d[mocd_pkg::LEN_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;

`ifndef ASSERT_OFF
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ({1'b0, rem_q} < div_q))
    else $error("modulo remainder not below divisor");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("modulo done without a run");
`endif

endmodule

FILE: hdl/mocd_dp.sv
// Datapath: configuration registers, beat counter, modulo unit and result stage.
module mocd_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mocd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mocd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                gate_level_i,
  input  logic                                reset_request_i,
  input  mocd_pkg::cmd_t                      cmd_i,
  output mocd_pkg::sts_t                      sts_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [mocd_pkg::NUM_OUTPUTS-1:0]    gate_outputs_o,
  output logic                                at_zero_o,
  output logic [mocd_pkg::CNT_W-1:0]          beat_count_o
);

  logic [mocd_pkg::LEN_W-1:0]       len_q;
  logic [mocd_pkg::DIV_W-1:0]       divisors_q [mocd_pkg::NUM_OUTPUTS];
  logic [mocd_pkg::NUM_OUTPUTS-1:0] bb_mask_q;
  logic [mocd_pkg::CNT_W-1:0]       cnt_q;
  logic                             prev_q;
  logic                             gate_q;
  logic                             req_q;
  logic                             edge_q;
  logic [mocd_pkg::NUM_OUTPUTS-1:0] bits_q;
  logic                             out_valid_q;
  logic [mocd_pkg::NUM_OUTPUTS-1:0] out_bits_q;
  logic [mocd_pkg::CNT_W-1:0]       out_cnt_q;

  logic [mocd_pkg::LEN_W-1:0]       len_eff;
  logic [mocd_pkg::CNT_W-1:0]       len_last;
  logic [mocd_pkg::DIV_W-1:0]       div_raw;
  logic [mocd_pkg::DIV_W-1:0]       div_eff;
  logic [mocd_pkg::LEN_W-1:0]       half;
  logic                             pass;
  logic [mocd_pkg::LEN_W-1:0]       mod_dividend;
  logic [mocd_pkg::DIV_W-1:0]       mod_divisor;
  logic                             mod_busy;
  logic                             mod_done;
  logic [mocd_pkg::LEN_W-1:0]       mod_rem;
  logic                             bit_d;
  logic [mocd_pkg::OUT_IDX_W-1:0]   cfg_div_idx;

  // Clamp length to 1..LEN_MAX and divisors to 1..DIV_MAX.
  always_comb begin
    priority if (len_q == '0)     len_eff = mocd_pkg::LEN_W'(1);
    else if (len_q > mocd_pkg::LEN_MAX) len_eff = mocd_pkg::LEN_MAX;
    else                          len_eff = len_q;
    len_last = mocd_pkg::CNT_W'(len_eff - 1'b1);

    div_raw = divisors_q[cmd_i.out_idx];
    priority if (div_raw == '0)        div_eff = mocd_pkg::DIV_W'(1);
    else if (div_raw > mocd_pkg::DIV_MAX) div_eff = mocd_pkg::DIV_MAX;
    else                               div_eff = div_raw;
    pass = (div_eff == mocd_pkg::DIV_W'(1));
    half = div_eff[mocd_pkg::DIV_W-1:1];
  end

  always_comb begin
    if (cmd_i.div_wrap) begin
      mod_dividend = mocd_pkg::LEN_W'(cnt_q) + 1'b1;
      mod_divisor  = {1'b0, len_eff};
    end else begin
      mod_dividend = mocd_pkg::LEN_W'(cnt_q);
      mod_divisor  = div_eff;
    end
  end

  mocd_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (mod_dividend),
    .divisor_i  (mod_divisor),
    .busy_o     (mod_busy),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  always_comb begin
    if (pass) begin
      bit_d = gate_q;
    end else if (bb_mask_q[cmd_i.out_idx]) begin
      bit_d = (mod_rem >= half);
    end else begin
      bit_d = (mod_rem < half);
    end
  end

  assign cfg_div_idx = mocd_pkg::OUT_IDX_W'(cfg_index_i - mocd_pkg::REG_DIVISOR_OUT1);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= mocd_pkg::RESET_LENGTH_RST;
      bb_mask_q <= mocd_pkg::BACKBEAT_MASK_RST;
      for (int i = 0; i < mocd_pkg::NUM_OUTPUTS; i++) begin
        divisors_q[i] <= mocd_pkg::divisor_rst(mocd_pkg::OUT_IDX_W'(i));
      end
    end else if (cfg_we_i) begin
      priority if (cfg_index_i == mocd_pkg::REG_RESET_LENGTH) begin
        len_q <= cfg_data_i[mocd_pkg::LEN_W-1:0];
      end else if (cfg_index_i == mocd_pkg::REG_BACKBEAT_MASK) begin
        bb_mask_q <= cfg_data_i[mocd_pkg::NUM_OUTPUTS-1:0];
      end else begin
        divisors_q[cfg_div_idx] <= cfg_data_i;
      end
    end
  end

  // Beat counter, edge detect and result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      prev_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        prev_q <= gate_level_i;
      end
      if (cmd_i.wrap_commit) begin
        cnt_q <= mod_rem[mocd_pkg::CNT_W-1:0];
      end else if (cmd_i.req_load) begin
        cnt_q <= len_last;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      gate_q <= gate_level_i;
      req_q  <= reset_request_i;
      edge_q <= gate_level_i & ~prev_q;
    end
    if (cmd_i.bit_commit) begin
      bits_q[cmd_i.out_idx] <= bit_d;
    end
    if (cmd_i.emit) begin
      out_bits_q <= bits_q;
      out_cnt_q  <= cnt_q;
    end
  end

  assign sts_o = '{
    edge_seen: edge_q,
    req_seen:  req_q,
    div_busy:  mod_busy,
    div_done:  mod_done,
    pass:      pass,
    out_free:  ~out_valid_q | ~out_stall_i
  };

  assign out_valid_o    = out_valid_q;
  assign gate_outputs_o = out_bits_q;
  assign beat_count_o   = out_cnt_q;
  assign at_zero_o      = (out_cnt_q == '0);

`ifndef ASSERT_OFF
  a_req_loads_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.req_load && !cmd_i.wrap_commit |=> cnt_q == $past(len_last))
    else $error("reset request did not load length minus one");
  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.emit))
    else $error("result appeared without emit");
`endif

endmodule

FILE: hdl/mocd_ctrl.sv
// Controller: sequences capture, counter wrap, reset load, the six output bits and the emit.
module mocd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mocd_pkg::sts_t sts_i,
  output mocd_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WRAP,
    ST_REQ,
    ST_OUT,
    ST_OUT_WAIT,
    ST_EMIT
  } state_e;

  localparam logic [mocd_pkg::OUT_IDX_W-1:0] LAST_IDX =
    mocd_pkg::OUT_IDX_W'(mocd_pkg::NUM_OUTPUTS - 1);

  state_e                         state_q;
  logic [mocd_pkg::OUT_IDX_W-1:0] idx_q;

  always_comb begin
    cmd_o             = '0;
    cmd_o.out_idx     = idx_q;
    cmd_o.capture     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.div_start   = ((state_q == ST_CHECK) && sts_i.edge_seen) ||
                        ((state_q == ST_OUT) && !sts_i.pass);
    cmd_o.div_wrap    = (state_q == ST_CHECK) || (state_q == ST_WRAP);
    cmd_o.wrap_commit = (state_q == ST_WRAP) && sts_i.div_done;
    cmd_o.req_load    = (state_q == ST_REQ) && sts_i.req_seen;
    cmd_o.bit_commit  = ((state_q == ST_OUT) && sts_i.pass) ||
                        ((state_q == ST_OUT_WAIT) && sts_i.div_done);
    cmd_o.emit        = (state_q == ST_EMIT) && sts_i.out_free;
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          state_q <= sts_i.edge_seen ? ST_WRAP : ST_REQ;
        end
        ST_WRAP: begin
          if (sts_i.div_done) state_q <= ST_REQ;
        end
        ST_REQ: begin
          idx_q   <= '0;
          state_q <= ST_OUT;
        end
        ST_OUT, ST_OUT_WAIT: begin
          if (cmd_o.bit_commit) begin
            if (idx_q == LAST_IDX) begin
              state_q <= ST_EMIT;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= ST_OUT;
            end
          end else if (state_q == ST_OUT) begin
            state_q <= ST_OUT_WAIT;
          end
        end
        ST_EMIT: begin
          if (sts_i.out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !sts_i.div_busy)
    else $error("modulo unit started while busy");
`endif

endmodule

FILE: hdl/multi_output_clock_divider.sv
// Each input beat runs check, a counter wrap after a rising edge, the reset load when requested,
// then each output in turn (a modulo run when its divisor is above one, else a direct commit)
// and the emit. in_stall_o holds until the emit, which a stalled result stage delays, so
// a new input beat is taken only once the last one is emitted. Reset (rst_ni low,
// asynchronous): counter and edge history clear, registers return to length 32, divisors
// 1,2,4,8,3,5, backbeat mask 0.
module multi_output_clock_divider (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mocd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mocd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input beats
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                gate_level_i,
  input  logic                                reset_request_i,
  // result beats
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [mocd_pkg::NUM_OUTPUTS-1:0]    gate_outputs_o,
  output logic                                at_zero_o,
  output logic [mocd_pkg::CNT_W-1:0]          beat_count_o
);

  mocd_pkg::cmd_t cmd;
  mocd_pkg::sts_t sts;

  // The user must write registers only while idle; not enforced, so always take the write.
  assign cfg_ready_o = 1'b1;

  // Controller: walks capture, wrap, reset load, each output in turn, then the emit.
  mocd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: counter, divisors, shared modulo unit and the result register.
  mocd_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .gate_level_i    (gate_level_i),
    .reset_request_i (reset_request_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .gate_outputs_o  (gate_outputs_o),
    .at_zero_o       (at_zero_o),
    .beat_count_o    (beat_count_o)
  );

endmodule

FILE: tb/tb.sv
// Self-checking testbench of the six-output gate clock divider.
`timescale 1ns / 1ps

module tb;
  import mocd_pkg::*;

  // Give up after this many cycles with no beat and no register write moving.
  localparam int unsigned STALL_LIMIT  = 4000;
  // Cycles to let pass after the last result before a register write or the end.
  localparam int unsigned SETTLE_WAIT  = 80;
  localparam int unsigned PHASES       = 9;
  localparam int unsigned PHASE_BEATS  = 150;

  typedef struct packed {
    logic [NUM_OUTPUTS-1:0] gates;
    logic                   zero;
    logic [CNT_W-1:0]       count;
  } divider_out_t;

  typedef enum logic [0:0] {ROW_WRITE, ROW_BEAT} row_kind_e;

  // One row of the directed table: either a register write or an input beat,
  // the latter with an optional typed-in result.
  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic                   gate;
    logic                   req;
    logic                   typed;
    divider_out_t           res;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   gate_level = 1'b0;
  logic                   reset_request = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [NUM_OUTPUTS-1:0] gate_outputs;
  logic                   at_zero;
  logic [CNT_W-1:0]       beat_count;

  // Shadow of the registers and state of the divider.
  logic [LEN_W-1:0]       len_reg = 8'd32;
  logic [DIV_W-1:0]       div_reg [NUM_OUTPUTS] = '{9'd1, 9'd2, 9'd4, 9'd8, 9'd3, 9'd5};
  logic [NUM_OUTPUTS-1:0] bb_mask = '0;
  logic [CNT_W-1:0]       beat_cnt = '0;
  logic                   prev_gate = 1'b0;

  divider_out_t           pending_q [$];
  stim_row_t              dir_rows [$];
  int unsigned            mismatches = 0;
  int unsigned            stall_left = 0;
  int unsigned            quiet_cycles = 0;
  bit                     no_idle = 1'b0;

  multi_output_clock_divider dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .gate_level_i    (gate_level),
    .reset_request_i (reset_request),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .gate_outputs_o  (gate_outputs),
    .at_zero_o       (at_zero),
    .beat_count_o    (beat_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the shadow counter by one input beat and work out the divided gates.
  // Zero length acts as one, lengths above the counter span clamp to 128;
  // zero divisors act as one, divisors above 256 clamp to 256.
  function automatic divider_out_t divide_step(input logic g, input logic r);
    int unsigned  len;
    int unsigned  d;
    int unsigned  ph;
    divider_out_t res;
    len = (len_reg == '0) ? 1 : int'(len_reg);
    if (len > 128) len = 128;
    // A rising edge wraps first; a reset request in the same beat wins.
    if (g && !prev_gate) beat_cnt = CNT_W'((beat_cnt + 1) % len);
    prev_gate = g;
    if (r) beat_cnt = CNT_W'(len - 1);
    res.gates = '0;
    for (int i = 0; i < NUM_OUTPUTS; i++) begin
      d = div_reg[i];
      if (d == 0) d = 1;
      if (d > 256) d = 256;
      if (d == 1) begin
        res.gates[i] = g;
      end else begin
        ph = beat_cnt % d;
        res.gates[i] = bb_mask[i] ? (ph >= d / 2) : (ph < d / 2);
      end
    end
    res.zero  = (beat_cnt == '0);
    res.count = beat_cnt;
    return res;
  endfunction

  function automatic stim_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_WRITE;
    row.idx  = idx;
    row.data = data;
    return row;
  endfunction

  function automatic stim_row_t beat_row(input logic g, input logic r);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_BEAT;
    row.gate = g;
    row.req  = r;
    return row;
  endfunction

  function automatic stim_row_t known_row(input logic g, input logic r,
                                          input logic [NUM_OUTPUTS-1:0] gates,
                                          input logic zero, input logic [CNT_W-1:0] count);
    stim_row_t row;
    row       = beat_row(g, r);
    row.typed = 1'b1;
    row.res   = '{gates, zero, count};
    return row;
  endfunction

  // Drive one input beat after a random gap; queue its result on acceptance.
  task automatic send_beat(input logic g, input logic r, input logic typed,
                           input divider_out_t typed_res);
    int unsigned  gap;
    divider_out_t pred;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    gate_level    <= g;
    reset_request <= r;
    do @(posedge clk); while (in_stall);
    pred = divide_step(g, r);
    pending_q.push_back(typed ? typed_res : pred);
  endtask

  // Drop valid and hold until every queued result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // Drain, then let the block settle before touching its registers.
  task automatic wait_idle();
    drain_results();
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_RESET_LENGTH) begin
      len_reg = data[LEN_W-1:0];
    end else if (idx == REG_BACKBEAT_MASK) begin
      bb_mask = data[NUM_OUTPUTS-1:0];
    end else begin
      div_reg[idx - REG_DIVISOR_OUT1] = data;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Set all registers for one random phase: extremes first, then mostly small
  // lengths and divisors so the counter wraps often.
  task automatic set_phase(input int unsigned ph);
    logic [CFG_DATA_W-1:0] len_val;
    logic [CFG_DATA_W-1:0] div_val;
    logic [CFG_DATA_W-1:0] mask_val;
    case (ph)
      0: begin
        len_val  = 9'd255;
        mask_val = 9'h1FF;
      end
      1: begin
        len_val  = 9'd0;
        mask_val = 9'd0;
      end
      2: begin
        len_val  = 9'd128;
        mask_val = 9'h02A;
      end
      3: begin
        len_val  = 9'd1;
        mask_val = 9'd63;
      end
      default: begin
        len_val  = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 511))
                                               : CFG_DATA_W'($urandom_range(1, 16));
        mask_val = CFG_DATA_W'($urandom_range(0, 511));
      end
    endcase
    write_reg(REG_RESET_LENGTH, len_val);
    for (int i = 0; i < NUM_OUTPUTS; i++) begin
      case (ph)
        0:       div_val = 9'd511;
        1:       div_val = 9'd0;
        2:       div_val = 9'd256;
        3:       div_val = 9'd1;
        default: div_val = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(0, 511))
                                                       : CFG_DATA_W'($urandom_range(1, 12));
      endcase
      write_reg(REG_DIVISOR_OUT1 + CFG_IDX_W'(i), div_val);
    end
    write_reg(REG_BACKBEAT_MASK, mask_val);
  endtask

  // Receiver: hold stall for the drawn number of cycles after each result beat.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result beat against the oldest queued prediction.
  always @(posedge clk) begin : result_check
    divider_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected: gates=%h zero=%b count=%0d",
               gate_outputs, at_zero, beat_count);
        mismatches++;
      end else begin
        want = pending_q.pop_front();
        if (gate_outputs !== want.gates) begin
          $error("gate_outputs: expected %h, got %h", want.gates, gate_outputs);
          mismatches++;
        end
        if (at_zero !== want.zero) begin
          $error("at_zero: expected %b, got %b", want.zero, at_zero);
          mismatches++;
        end
        if (beat_count !== want.count) begin
          $error("beat_count: expected %0d, got %0d", want.count, beat_count);
          mismatches++;
        end
      end
      stall_left <= no_idle ? 0 : $urandom_range(0, 5);
    end
  end

  // Watchdog: count cycles in which no beat or register write is accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    stim_row_t row;
    logic      busy;
    logic      g;
    // Power-up defaults, then an edge, a plain reset request and a wrap at 32.
    dir_rows.push_back(known_row(1'b0, 1'b0, 6'h3E, 1'b1, 7'd0));
    dir_rows.push_back(known_row(1'b1, 1'b0, 6'h2D, 1'b0, 7'd1));
    dir_rows.push_back(known_row(1'b1, 1'b1, 6'h21, 1'b0, 7'd31));
    dir_rows.push_back(beat_row(1'b0, 1'b0));
    dir_rows.push_back(known_row(1'b1, 1'b0, 6'h3F, 1'b1, 7'd0));
    // Edge and reset request in the same beat.
    dir_rows.push_back(beat_row(1'b0, 1'b0));
    dir_rows.push_back(beat_row(1'b1, 1'b1));
    // Zero length, zero and oversized divisors, full backbeat mask.
    dir_rows.push_back(write_row(REG_RESET_LENGTH, 9'd0));
    dir_rows.push_back(write_row(REG_DIVISOR_OUT1, 9'd0));
    dir_rows.push_back(write_row(REG_DIVISOR_OUT1 + 3'd1, 9'd511));
    dir_rows.push_back(write_row(REG_DIVISOR_OUT1 + 3'd2, 9'd256));
    dir_rows.push_back(write_row(REG_DIVISOR_OUT1 + 3'd3, 9'd2));
    dir_rows.push_back(write_row(REG_DIVISOR_OUT1 + 3'd4, 9'd3));
    dir_rows.push_back(write_row(REG_DIVISOR_OUT1 + 3'd5, 9'd257));
    dir_rows.push_back(write_row(REG_BACKBEAT_MASK, 9'd63));
    dir_rows.push_back(beat_row(1'b0, 1'b0));
    dir_rows.push_back(beat_row(1'b1, 1'b0));
    dir_rows.push_back(beat_row(1'b0, 1'b1));
    // Oversized length saturates to 128; reset request lands on 127.
    dir_rows.push_back(write_row(REG_RESET_LENGTH, 9'd255));
    dir_rows.push_back(write_row(REG_DIVISOR_OUT1, 9'd1));
    for (int i = 1; i < NUM_OUTPUTS; i++) begin
      dir_rows.push_back(write_row(REG_DIVISOR_OUT1 + CFG_IDX_W'(i), 9'd256));
    end
    dir_rows.push_back(write_row(REG_BACKBEAT_MASK, 9'd0));
    dir_rows.push_back(known_row(1'b0, 1'b1, 6'h3E, 1'b0, 7'd127));
    // Lower the length under the counter: it holds until the next edge wraps it.
    dir_rows.push_back(write_row(REG_RESET_LENGTH, 9'd4));
    dir_rows.push_back(beat_row(1'b0, 1'b0));
    dir_rows.push_back(known_row(1'b1, 1'b0, 6'h3F, 1'b1, 7'd0));
    dir_rows.push_back(write_row(REG_RESET_LENGTH, 9'd128));
    dir_rows.push_back(beat_row(1'b0, 1'b1));
    dir_rows.push_back(beat_row(1'b1, 1'b0));
    dir_rows.push_back(write_row(REG_BACKBEAT_MASK, 9'd63));
    dir_rows.push_back(known_row(1'b0, 1'b0, 6'h00, 1'b1, 7'd0));
    // All divisors one: every output follows the gate.
    for (int i = 0; i < NUM_OUTPUTS; i++) begin
      dir_rows.push_back(write_row(REG_DIVISOR_OUT1 + CFG_IDX_W'(i), 9'd1));
    end
    dir_rows.push_back(known_row(1'b1, 1'b0, 6'h3F, 1'b0, 7'd1));
    dir_rows.push_back(known_row(1'b0, 1'b0, 6'h00, 1'b0, 7'd1));
    dir_rows.push_back(write_row(REG_RESET_LENGTH, 9'd1));
    dir_rows.push_back(known_row(1'b1, 1'b0, 6'h3F, 1'b1, 7'd0));

    // Hold reset low, then release it at a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table; settle the block before each run of writes.
    busy = 1'b0;
    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      if (row.kind == ROW_WRITE) begin
        if (busy) wait_idle();
        busy = 1'b0;
        write_reg(row.idx, row.data);
      end else begin
        send_beat(row.gate, row.req, row.typed, row.res);
        busy = 1'b1;
      end
    end

    // Random phases: reprogram, then stream beats with a toggling gate and
    // occasional reset requests. Every third phase runs without idling.
    g = 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      set_phase(ph);
      no_idle = (ph % 3 == 2);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if ($urandom_range(0, 99) == 0) drain_results();
        if ($urandom_range(0, 1) == 0) g = ~g;
        send_beat(g, $urandom_range(0, 11) == 0, 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    // Drop valid, drain, and give stray results a chance to show up.
    drain_results();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
